// ----- sv/fatlb_pkg.sv -----
// ----------------------------------------------------------------------------
// fatlb_pkg
// shared sizes, operation codes and controller/datapath link types
// ----------------------------------------------------------------------------
package fatlb_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int OP_W    = 2;
	localparam int PID_W   = 8;
	localparam int PAGE_W  = 20;
	localparam int STAMP_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
		logic scan_start;
		logic scan_step;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} sts_t;

endpackage

// ----- sv/fatlb_dp.sv -----
// ----------------------------------------------------------------------------
// fatlb_dp
// entry storage, parallel vpn match, victim select with stamp scan, result word
// ----------------------------------------------------------------------------
module fatlb_dp
	import fatlb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [OP_W-1:0]   operation,
	input  logic [PID_W-1:0]  process_id,
	input  logic [PAGE_W-1:0] virtual_page,
	input  logic [PAGE_W-1:0] physical_page,
	output logic              hit,
	output logic [PAGE_W-1:0] frame
);

	// request word
	op_t                req_op_q;
	logic [PID_W-1:0]   req_pid_q;
	logic [PAGE_W-1:0]  req_vpn_q;
	logic [PAGE_W-1:0]  req_ppn_q;

	// entry state
	logic [ENTRIES-1:0] valid_q;
	logic [PAGE_W-1:0]  vpn_q   [ENTRIES];
	logic [PAGE_W-1:0]  ppn_q   [ENTRIES];
	logic [STAMP_W-1:0] stamp_q [ENTRIES];
	logic [STAMP_W-1:0] use_cnt_q;
	logic [PID_W-1:0]   owner_q;

	// stamp scan
	logic [IDX_W-1:0]   scan_idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;

	// result word
	logic               hit_q;
	logic [PAGE_W-1:0]  frame_q;

	logic               pid_eq;
	logic [ENTRIES-1:0] match_vec;
	logic [IDX_W-1:0]   match_idx;
	logic               match_any;
	logic [IDX_W-1:0]   free_idx;
	logic               free_any;
	logic [IDX_W-1:0]   victim;
	logic               lookup_hit;
	logic [STAMP_W-1:0] scan_stamp;

	assign pid_eq = (req_pid_q == owner_q);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (vpn_q[i] == req_vpn_q);
		end
	end

	// lowest index wins
	always_comb begin
		match_idx = '0;
		match_any = 1'b0;
		free_idx  = '0;
		free_any  = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				match_idx = IDX_W'(i);
				match_any = 1'b1;
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	// new owner empties the buffer, so entry zero is the first free one
	always_comb begin
		if (!pid_eq) begin
			victim = '0;
		end else if (free_any) begin
			victim = free_idx;
		end else begin
			victim = best_idx_q;
		end
	end

	assign lookup_hit = (req_op_q == OP_LOOKUP) && pid_eq && match_any;
	assign scan_stamp = stamp_q[scan_idx_q];

	assign sts.need_scan = (req_op_q == OP_INSERT) && pid_eq && !free_any;
	assign sts.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_op_q  <= op_t'(operation);
			req_pid_q <= process_id;
			req_vpn_q <= virtual_page;
			req_ppn_q <= physical_page;
		end
		if (cmd.scan_start) begin
			scan_idx_q   <= IDX_W'(1);
			best_idx_q   <= '0;
			best_stamp_q <= stamp_q[0];
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (scan_stamp < best_stamp_q) begin
				best_idx_q   <= scan_idx_q;
				best_stamp_q <= scan_stamp;
			end
		end
		if (cmd.commit) begin
			hit_q   <= lookup_hit;
			frame_q <= lookup_hit ? ppn_q[match_idx] : '0;
			if (lookup_hit) begin
				stamp_q[match_idx] <= use_cnt_q;
			end
			if (req_op_q == OP_INSERT) begin
				vpn_q[victim]   <= req_vpn_q;
				ppn_q[victim]   <= req_ppn_q;
				stamp_q[victim] <= use_cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			use_cnt_q <= '0;
			owner_q   <= '0;
		end else if (cmd.commit) begin
			case (req_op_q)
				OP_LOOKUP: begin
					if (lookup_hit) begin
						use_cnt_q <= use_cnt_q + STAMP_W'(1);
					end
				end
				OP_INSERT: begin
					if (!pid_eq) begin
						valid_q <= ENTRIES'(1);
						owner_q <= req_pid_q;
					end else begin
						valid_q[victim] <= 1'b1;
					end
					use_cnt_q <= use_cnt_q + STAMP_W'(1);
				end
				OP_REMOVE: begin
					if (pid_eq && match_any) begin
						valid_q[match_idx] <= 1'b0;
					end
				end
				OP_FLUSH: begin
					valid_q <= '0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	assign hit   = hit_q;
	assign frame = frame_q;

endmodule

// ----- sv/fatlb_ctrl.sv -----
// ----------------------------------------------------------------------------
// fatlb_ctrl
// request sequencer and result word handshake
// ----------------------------------------------------------------------------
module fatlb_ctrl
	import fatlb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd.load       = 1'b0;
		cmd.commit     = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.scan_step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/fully_associative_tlb_lru_core.sv -----
// ----------------------------------------------------------------------------
// fully_associative_tlb_lru_core
// fully associative translation buffer, one owner pid, lru replacement
// ----------------------------------------------------------------------------
// sequence: a request is loaded in idle and committed to the result register from
//   the compare state, or, for an insert into a full buffer, from the final state
//   after the min-stamp scan that reads one stamp per cycle; a commit waits while the
//   result word is still unaccepted, and no new request is taken until the commit
// reset: arst_n clears all valid bits, the use counter, the owner pid, the
//   sequencer and the result word valid; no clearing pass is needed
module fully_associative_tlb_lru_core
	import fatlb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request word
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [PID_W-1:0]  process_id,
	input  logic [PAGE_W-1:0] virtual_page,
	input  logic [PAGE_W-1:0] physical_page,
	// result word
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [PAGE_W-1:0] frame
);

	// controller/datapath link
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, compare/commit, stamp scan, final commit
	fatlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entries, parallel vpn match, victim choice and the result register
	fatlb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.process_id    (process_id),
		.virtual_page  (virtual_page),
		.physical_page (physical_page),
		.hit           (hit),
		.frame         (frame)
	);

`ifndef SYNTHESIS
	// a result only lands in a free or draining result register
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result committed over a pending word");

	// a miss or a non-lookup word carries a zero frame
	a_miss_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (frame == '0))
		else $error("frame nonzero without hit");

	// one request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");
`endif

endmodule

// ----- test/fully_associative_tlb_lru_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fully_associative_tlb_lru_core_test
// self-checking bench: a predictor of the translation buffer with lru
// replacement checks every result word, with random idling on both sides
// ----------------------------------------------------------------------------
module fully_associative_tlb_lru_core_test;
	import fatlb_pkg::*;

	// predictor of the buffer plus the list of result words still due
	class tlb_scoreboard;
		typedef struct {
			bit                hit;
			logic [PAGE_W-1:0] frame;
		} xlate_t;

		bit                 ent_valid [ENTRIES];
		logic [PAGE_W-1:0]  ent_vpn   [ENTRIES];
		logic [PAGE_W-1:0]  ent_ppn   [ENTRIES];
		logic [STAMP_W-1:0] ent_stamp [ENTRIES];
		logic [STAMP_W-1:0] use_count;
		logic [PID_W-1:0]   owner;
		xlate_t             due [$];
		int                 failures;
		int                 checked;
		int                 hits;
		int                 evictions;
		int                 owner_changes;

		function new();
			foreach (ent_valid[i]) begin
				ent_valid[i] = 1'b0;
				ent_vpn[i]   = '0;
				ent_ppn[i]   = '0;
				ent_stamp[i] = '0;
			end
			use_count = '0;
			owner     = '0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// lowest-indexed valid entry holding this page, -1 if none
		function int find_page(logic [PAGE_W-1:0] vpn);
			for (int i = 0; i < ENTRIES; i++)
				if (ent_valid[i] && ent_vpn[i] == vpn)
					return i;
			return -1;
		endfunction

		function void note_request(op_t op, logic [PID_W-1:0] pid,
				logic [PAGE_W-1:0] vpn, logic [PAGE_W-1:0] ppn);
			xlate_t res;
			int     idx;
			res.hit   = 1'b0;
			res.frame = '0;
			case (op)
			OP_LOOKUP: begin
				idx = (pid == owner) ? find_page(vpn) : -1;
				if (idx >= 0) begin
					ent_stamp[idx] = use_count;
					use_count++;
					res.hit   = 1'b1;
					res.frame = ent_ppn[idx];
				end
			end
			OP_INSERT: begin
				// a new owner starts from an empty buffer
				if (pid != owner) begin
					foreach (ent_valid[i])
						ent_valid[i] = 1'b0;
					owner = pid;
					owner_changes++;
				end
				idx = -1;
				for (int i = 0; i < ENTRIES && idx < 0; i++)
					if (!ent_valid[i])
						idx = i;
				// full: plain unsigned min stamp, lowest index on a tie
				if (idx < 0) begin
					idx = 0;
					for (int i = 1; i < ENTRIES; i++)
						if (ent_stamp[i] < ent_stamp[idx])
							idx = i;
					evictions++;
				end
				ent_valid[idx] = 1'b1;
				ent_vpn[idx]   = vpn;
				ent_ppn[idx]   = ppn;
				ent_stamp[idx] = use_count;
				use_count++;
			end
			OP_REMOVE: begin
				idx = (pid == owner) ? find_page(vpn) : -1;
				if (idx >= 0)
					ent_valid[idx] = 1'b0;
			end
			default: begin
				foreach (ent_valid[i])
					ent_valid[i] = 1'b0;
			end
			endcase
			due.push_back(res);
		endfunction

		function void check_result(bit h, logic [PAGE_W-1:0] f);
			xlate_t want;
			if (due.size() == 0) begin
				$display("%0t: result word with nothing due: hit %0b frame %05h", $time, h, f);
				failures++;
				return;
			end
			want = due.pop_front();
			checked++;
			if (want.hit)
				hits++;
			if (h !== want.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, want.hit, h);
				failures++;
			end
			if (f !== want.frame) begin
				$display("%0t: frame expected %05h actual %05h", $time, want.frame, f);
				failures++;
			end
		endfunction
	endclass

	localparam int RANDOM_ITEMS = 700;
	localparam int POOL_SIZE    = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   operation     = OP_LOOKUP;
	logic [PID_W-1:0]  process_id    = '0;
	logic [PAGE_W-1:0] virtual_page  = '0;
	logic [PAGE_W-1:0] physical_page = '0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic              hit;
	logic [PAGE_W-1:0] frame;

	tlb_scoreboard     sb;
	bit                gaps_on = 1'b1;      // random idling on both sides
	int                requests_sent;
	int                cycle_count;
	logic [PAGE_W-1:0] page_pool [POOL_SIZE];

	fully_associative_tlb_lru_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.process_id   (process_id),
		.virtual_page (virtual_page),
		.physical_page(physical_page),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.frame        (frame)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result side: check each accepted word, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(hit, frame);
			out_ready <= !(gaps_on && $urandom_range(99) < 38);
		end
	end

	// watchdog, far above the slowest legal run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fully_associative_tlb_lru_core: mismatch");
		$finish;
	end

	// drive one request word, idling first at random; returns on the accepting edge
	task automatic send_request(op_t op, logic [PID_W-1:0] pid,
			logic [PAGE_W-1:0] vpn, logic [PAGE_W-1:0] ppn);
		while (gaps_on && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		process_id    <= pid;
		virtual_page  <= vpn;
		physical_page <= ppn;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(op, pid, vpn, ppn);
		requests_sent++;
	endtask

	// hold the request side quiet until every result word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		int                r;
		op_t               op;
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] vpn;
		logic [PAGE_W-1:0] ppn;

		sb = new();
		foreach (page_pool[i])
			page_pool[i] = PAGE_W'($urandom);
		// page extremes live in the pool too
		page_pool[0] = '0;
		page_pool[1] = '1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, page extremes, foreign pid, duplicates, remove, flush
		send_request(OP_LOOKUP, 8'h00, 20'h00000, 20'h00000);
		send_request(OP_INSERT, 8'h00, 20'h00000, 20'hFFFFF);
		send_request(OP_INSERT, 8'h00, 20'hFFFFF, 20'h00000);
		send_request(OP_LOOKUP, 8'h00, 20'h00000, 20'h00000);
		send_request(OP_LOOKUP, 8'h00, 20'hFFFFF, 20'hFFFFF);
		send_request(OP_LOOKUP, 8'hFF, 20'h00000, 20'h00000);
		send_request(OP_REMOVE, 8'hFF, 20'h00000, 20'h00000);
		// duplicate page: lookup must see the lower entry
		send_request(OP_INSERT, 8'h00, 20'h00000, 20'h12345);
		send_request(OP_LOOKUP, 8'h00, 20'h00000, 20'h00000);
		send_request(OP_REMOVE, 8'h00, 20'h00000, 20'h00000);
		send_request(OP_LOOKUP, 8'h00, 20'h00000, 20'h00000);
		send_request(OP_REMOVE, 8'h00, 20'hABCDE, 20'h00000);
		// flush from any pid keeps the owner
		send_request(OP_FLUSH, 8'hFF, 20'hFFFFF, 20'hFFFFF);
		send_request(OP_LOOKUP, 8'h00, 20'hFFFFF, 20'h00000);
		// insert under a new pid clears the old owner's entries
		send_request(OP_INSERT, 8'h00, 20'h0F0F0, 20'h0F0F0);
		send_request(OP_INSERT, 8'hFF, 20'h55555, 20'hAAAAA);
		send_request(OP_LOOKUP, 8'h00, 20'h55555, 20'h00000);
		send_request(OP_LOOKUP, 8'hFF, 20'h0F0F0, 20'h00000);
		send_request(OP_LOOKUP, 8'hFF, 20'h55555, 20'h00000);

		// random: mostly owner traffic over a page pool a bit larger than the
		// buffer, so it fills and lru eviction kicks in; the rest is noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 350 && n < 470);
			if (n == 200)
				drain_results();
			r  = $urandom_range(99);
			op = (r < 48) ? OP_LOOKUP : (r < 83) ? OP_INSERT : (r < 97) ? OP_REMOVE : OP_FLUSH;
			pid = sb.owner;
			if ($urandom_range(99) < ((op == OP_INSERT) ? 4 : 10))
				pid = PID_W'($urandom_range(255));
			if ($urandom_range(99) < 85)
				vpn = page_pool[$urandom_range(POOL_SIZE - 1)];
			else
				vpn = PAGE_W'($urandom);
			ppn = PAGE_W'($urandom);
			send_request(op, pid, vpn, ppn);
		end
		gaps_on = 1'b1;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d result words checked, %0d hits",
			requests_sent, sb.checked, sb.hits);
		$display("lru evictions %0d, owner pid changes %0d", sb.evictions, sb.owner_changes);
		if (sb.failures == 0)
			$display("fully_associative_tlb_lru_core: match");
		else
			$display("fully_associative_tlb_lru_core: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fatlb_pkg.sv
sv/fatlb_dp.sv
sv/fatlb_ctrl.sv
sv/fully_associative_tlb_lru_core.sv
test/fully_associative_tlb_lru_core_test.sv
